### sv/xsid_pkg.sv
package xsid_pkg;

   localparam int OFFSET_BITS_DEFAULT = 32;

   localparam logic [7:0] OPC_NOP        = 8'h90;
   localparam logic [7:0] OPC_RET        = 8'hC3;
   localparam logic [7:0] OPC_MOV_IMM_LO = 8'hB8;
   localparam logic [7:0] OPC_MOV_IMM_HI = 8'hBF;
   localparam logic [7:0] OPC_MOV_RM     = 8'h89;
   localparam logic [7:0] OPC_MOV_MR     = 8'h8B;
   localparam logic [7:0] OPC_ADD        = 8'h01;
   localparam logic [7:0] OPC_SUB        = 8'h29;
   localparam logic [7:0] OPC_JMP        = 8'hEB;
   localparam logic [1:0] MOD_REG        = 2'h3;
   localparam logic [2:0] IMM_BYTES      = 3'd4;

   typedef enum logic [2:0] {
      ST_OK,
      ST_BAD_OPCODE,
      ST_TRUNC_MODRM,
      ST_MEM_MODRM,
      ST_TRUNC_IMM,
      ST_TRUNC_DISP
   } status_type;

   typedef enum logic [2:0] {
      MN_NOP,
      MN_RET,
      MN_MOV,
      MN_ADD,
      MN_SUB,
      MN_JMP
   } mnemonic_type;

   typedef enum logic [1:0] {
      FM_NONE,
      FM_REG_IMM,
      FM_REG_REG,
      FM_REL
   } form_type;

   typedef struct packed {
      status_type   status;
      logic [31:0]  start_offset;
      mnemonic_type mnemonic;
      form_type     operand_form;
      logic [2:0]   dest_register;
      logic [2:0]   source_register;
      logic [31:0]  immediate_value;
      logic [33:0]  jump_target;
      logic [2:0]   instruction_length;
      logic [7:0]   error_opcode;
   } result_type;

endpackage

### sv/xsid_in_stage.sv
module xsid_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       advance,
   output logic       hold_valid,
   output logic [7:0] hold_byte,
   output logic       hold_last
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tvalid || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;
   assign hold_last  = last_ff;

endmodule

### sv/xsid_decode.sv
module xsid_decode #(
   parameter int OFFSET_BITS = xsid_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [7:0]           code_byte,
   input  logic                 end_of_stream,
   output logic                 res_valid,
   output xsid_pkg::result_type res
);

   typedef enum logic [1:0] {
      PH_OPCODE,
      PH_MODRM,
      PH_IMM,
      PH_DISP
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [7:0]             opcode_ff, opcode_in;
   logic [31:0]            imm_ff, imm_in;
   logic [2:0]             remain_ff, remain_in;
   logic                   discard_ff, discard_in;

   logic [63:0] start_ext;
   logic [1:0]  lane;
   logic [33:0] disp_ext;
   logic [1:0]  modrm_mod;
   logic [2:0]  modrm_reg, modrm_rm;

   function automatic logic [2:0] IMM_LANE(input logic [2:0] remain);
      return xsid_pkg::IMM_BYTES - remain;
   endfunction

   assign modrm_mod = code_byte[7:6];
   assign modrm_reg = code_byte[5:3];
   assign modrm_rm  = code_byte[2:0];
   assign lane      = 2'(IMM_LANE(remain_ff));
   assign disp_ext  = {{26{code_byte[7]}}, code_byte};
   assign start_ext = 64'(start_ff);

   always_comb begin
      phase_in   = phase_ff;
      offset_in  = offset_ff;
      start_in   = start_ff;
      opcode_in  = opcode_ff;
      imm_in     = imm_ff;
      remain_in  = remain_ff;
      discard_in = discard_ff;
      res_valid  = 1'b0;
      res        = '0;

      if (discard_ff) begin
         if (end_of_stream) begin
            phase_in   = PH_OPCODE;
            offset_in  = '0;
            remain_in  = '0;
            discard_in = 1'b0;
         end else begin
            offset_in = offset_ff + OFFSET_BITS'(1);
         end
      end else begin
         case (phase_ff)
            PH_MODRM: begin
               phase_in  = PH_OPCODE;
               res_valid = 1'b1;
               if (modrm_mod != xsid_pkg::MOD_REG) begin
                  res.status             = xsid_pkg::ST_MEM_MODRM;
                  res.instruction_length = 3'd2;
                  res.error_opcode       = opcode_ff;
                  discard_in             = 1'b1;
               end else begin
                  res.operand_form       = xsid_pkg::FM_REG_REG;
                  res.instruction_length = 3'd2;
                  res.dest_register      = modrm_rm;
                  res.source_register    = modrm_reg;
                  case (opcode_ff)
                     xsid_pkg::OPC_ADD: res.mnemonic = xsid_pkg::MN_ADD;
                     xsid_pkg::OPC_SUB: res.mnemonic = xsid_pkg::MN_SUB;
                     xsid_pkg::OPC_MOV_MR: begin
                        res.mnemonic        = xsid_pkg::MN_MOV;
                        res.dest_register   = modrm_reg;
                        res.source_register = modrm_rm;
                     end
                     default: res.mnemonic = xsid_pkg::MN_MOV;
                  endcase
               end
            end
            PH_IMM: begin
               imm_in    = imm_ff | (32'(code_byte) << {lane, 3'b000});
               remain_in = remain_ff - 3'd1;
               if (remain_in == 3'd0) begin
                  phase_in               = PH_OPCODE;
                  res_valid              = 1'b1;
                  res.mnemonic           = xsid_pkg::MN_MOV;
                  res.operand_form       = xsid_pkg::FM_REG_IMM;
                  res.dest_register      = opcode_ff[2:0];
                  res.immediate_value    = imm_in;
                  res.instruction_length = 3'd5;
               end
            end
            PH_DISP: begin
               phase_in               = PH_OPCODE;
               res_valid              = 1'b1;
               res.mnemonic           = xsid_pkg::MN_JMP;
               res.operand_form       = xsid_pkg::FM_REL;
               res.jump_target        = start_ext[33:0] + 34'd2 + disp_ext;
               res.instruction_length = 3'd2;
            end
            default: begin
               phase_in  = PH_OPCODE;
               start_in  = offset_ff;
               opcode_in = code_byte;
               if (code_byte == xsid_pkg::OPC_NOP) begin
                  res_valid              = 1'b1;
                  res.mnemonic           = xsid_pkg::MN_NOP;
                  res.instruction_length = 3'd1;
               end else if (code_byte == xsid_pkg::OPC_RET) begin
                  res_valid              = 1'b1;
                  res.mnemonic           = xsid_pkg::MN_RET;
                  res.instruction_length = 3'd1;
               end else if (code_byte inside
                            {[xsid_pkg::OPC_MOV_IMM_LO:xsid_pkg::OPC_MOV_IMM_HI]}) begin
                  phase_in  = PH_IMM;
                  remain_in = xsid_pkg::IMM_BYTES;
                  imm_in    = '0;
               end else if (code_byte inside {xsid_pkg::OPC_MOV_RM, xsid_pkg::OPC_MOV_MR,
                                              xsid_pkg::OPC_ADD, xsid_pkg::OPC_SUB}) begin
                  phase_in = PH_MODRM;
               end else if (code_byte == xsid_pkg::OPC_JMP) begin
                  phase_in = PH_DISP;
               end else begin
                  res_valid              = 1'b1;
                  res.status             = xsid_pkg::ST_BAD_OPCODE;
                  res.instruction_length = 3'd1;
                  res.error_opcode       = code_byte;
                  discard_in             = 1'b1;
               end
            end
         endcase

         offset_in = offset_ff + OFFSET_BITS'(1);

         if (end_of_stream) begin
            case (phase_in)
               PH_MODRM: begin
                  res_valid              = 1'b1;
                  res                    = '0;
                  res.status             = xsid_pkg::ST_TRUNC_MODRM;
                  res.instruction_length = 3'd1;
                  res.error_opcode       = opcode_in;
               end
               PH_IMM: begin
                  res_valid              = 1'b1;
                  res                    = '0;
                  res.status             = xsid_pkg::ST_TRUNC_IMM;
                  res.instruction_length = 3'd1 + (xsid_pkg::IMM_BYTES - remain_in);
                  res.error_opcode       = opcode_in;
               end
               PH_DISP: begin
                  res_valid              = 1'b1;
                  res                    = '0;
                  res.status             = xsid_pkg::ST_TRUNC_DISP;
                  res.instruction_length = 3'd1;
                  res.error_opcode       = opcode_in;
               end
               default: begin
               end
            endcase
            phase_in   = PH_OPCODE;
            offset_in  = '0;
            remain_in  = '0;
            discard_in = 1'b0;
         end
      end

      res.start_offset = 32'(start_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_OPCODE;
         offset_ff  <= '0;
         start_ff   <= '0;
         opcode_ff  <= '0;
         imm_ff     <= '0;
         remain_ff  <= '0;
         discard_ff <= 1'b0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         offset_ff  <= offset_in;
         start_ff   <= start_in;
         opcode_ff  <= opcode_in;
         imm_ff     <= imm_in;
         remain_ff  <= remain_in;
         discard_ff <= discard_in;
      end
   end

endmodule

### sv/xsid_out_stage.sv
module xsid_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 res_valid,
   input  xsid_pkg::result_type res,
   output logic                 take,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output xsid_pkg::result_type rsp_res
);

   logic                 valid_ff, valid_in;
   xsid_pkg::result_type res_ff;

   assign take     = !valid_ff || rsp_tready;
   assign valid_in = take ? (advance && res_valid) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take && advance && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_res    = res_ff;

endmodule

### sv/x86_subset_instruction_decoder_top.sv
// Decodes a 32-bit x86 subset (nop, ret, mov r32 imm32, add/sub/mov reg-reg, short jmp)
// from a stream of code bytes, one byte per request, with tlast on the final byte of
// each stream. One byte is taken every cycle unless the output is stalled; a result for
// the byte that finishes (or breaks) an instruction passes through the input register,
// one level of decode logic and the result register. An error result is followed by
// dropping bytes up to the end of the stream; every stream restarts at offset zero.
module x86_subset_instruction_decoder_top #(
   parameter int OFFSET_BITS = xsid_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // code_byte
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [119:0]  rsp_tdata,   // start_offset, mnemonic, operand_form, dest_register,
                                      // source_register, immediate_value, jump_target,
                                      // instruction_length, error_opcode
   output logic [2:0]    rsp_tuser    // status
);

   logic                 advance;
   logic                 take;
   logic                 hold_valid;
   logic [7:0]           hold_byte;
   logic                 hold_last;
   logic                 res_valid;
   xsid_pkg::result_type res;
   xsid_pkg::result_type rsp_res;

   assign advance = hold_valid && take;

   xsid_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_byte  (hold_byte),
      .hold_last  (hold_last)
   );

   xsid_decode #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_decode (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .code_byte     (hold_byte),
      .end_of_stream (hold_last),
      .res_valid     (res_valid),
      .res           (res)
   );

   xsid_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .res_valid  (res_valid),
      .res        (res),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   assign rsp_tuser = rsp_res.status;
   assign rsp_tdata = {rsp_res.error_opcode,
                       rsp_res.instruction_length,
                       rsp_res.jump_target,
                       rsp_res.immediate_value,
                       rsp_res.source_register,
                       rsp_res.dest_register,
                       rsp_res.operand_form,
                       rsp_res.mnemonic,
                       rsp_res.start_offset};

endmodule
